// File: src/efx_pkg.sv
// Shared types, codes and constants for the extension-field exponentiation core.
`default_nettype none
package efx_pkg;

  localparam int CW = 62;
  localparam int DEF_MAX_DEGREE = 16;
  localparam int DEF_EXP_BITS = 64;
  localparam int AW = 7;

  typedef logic [CW-1:0] coeff_t;

  localparam logic [1:0] REQ_LOAD_MOD  = 2'd0;
  localparam logic [1:0] REQ_LOAD_BASE = 2'd1;
  localparam logic [1:0] REQ_RUN       = 2'd2;

  localparam logic CFG_MODULUS = 1'b0;
  localparam logic CFG_DEGREE  = 1'b1;

  localparam logic [1:0] A_ONE = 2'd0;
  localparam logic [1:0] A_PW  = 2'd1;
  localparam logic [1:0] A_T   = 2'd2;

  localparam logic [2:0] B_CIN    = 3'd0;
  localparam logic [2:0] B_MSTORE = 3'd1;
  localparam logic [2:0] B_BSTORE = 3'd2;
  localparam logic [2:0] B_PR     = 3'd3;
  localparam logic [2:0] B_PW     = 3'd4;
  localparam logic [2:0] B_MREG   = 3'd5;

  localparam logic [2:0] W_NONE   = 3'd0;
  localparam logic [2:0] W_MSTORE = 3'd1;
  localparam logic [2:0] W_BSTORE = 3'd2;
  localparam logic [2:0] W_MREG   = 3'd3;
  localparam logic [2:0] W_PW     = 3'd4;
  localparam logic [2:0] W_TADD   = 3'd5;
  localparam logic [2:0] W_TSUB   = 3'd6;

  typedef struct packed {
    logic          cap;
    logic          a_ld;
    logic [1:0]    a_src;
    logic          go;
    logic [2:0]    b_src;
    logic [2:0]    w_dst;
    logic [AW-1:0] addr;
    logic          t_clr;
    logic          pr_init;
    logic          copy_pw;
    logic          copy_pr;
    logic          out_ld;
    logic          out_last;
  } efx_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_free;
  } efx_stat_t;

endpackage
`default_nettype wire

// File: src/ext_field_exponentiation_core.sv
// Top level of the extension-field exponentiation core: config registers and wiring.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | req_type, coef_pos, coeff_in, exponent
//  out     | out_valid / out_ready | coef_pos_out, coeff_out, last
//  cfg     | cfg_we (no wait)      | cfg_index, cfg_data
//
// One item at a time. All products run through one bit-serial modular multiplier.
// Load word: one reduction of coeff_in mod p. Run word: 2n setup products, then per
// exponent bit up to two ring products of n*n + (n-1)*n coefficient products each.
// Then n result words.
// Synchronous active-high reset; stores hold no reset value and no clearing pass.
// A stalled output keeps the sequencer waiting in its drain phase; input is
// taken again only after the last result word is in the output register.
`default_nettype none
module ext_field_exponentiation_core
  import efx_pkg::*;
#(
  parameter int MAX_DEGREE = DEF_MAX_DEGREE,
  parameter int EXP_BITS   = DEF_EXP_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [61:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [3:0]  coef_pos,
  input  wire logic [61:0] coeff_in,
  input  wire logic [63:0] exponent,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       coef_pos_out,
  output logic [61:0]      coeff_out,
  output logic             last
);
  localparam int NW = $clog2(MAX_DEGREE + 1);

  coeff_t        p_reg, p_eff;
  logic [4:0]    deg_reg;
  logic [NW-1:0] n_eff;
  efx_cmd_t      cmd;
  efx_stat_t     stat;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      p_reg   <= coeff_t'(2);
      deg_reg <= 5'd1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODULUS) p_reg <= cfg_data;
      else deg_reg <= cfg_data[4:0];
    end
  end

  // clamp p to at least 2 and n into 1..MAX_DEGREE
  always_comb begin
    p_eff = (p_reg < coeff_t'(2)) ? coeff_t'(2) : p_reg;
    if (deg_reg == '0) n_eff = NW'(1);
    else if (32'(deg_reg) > MAX_DEGREE) n_eff = NW'(MAX_DEGREE);
    else n_eff = NW'(deg_reg);
  end

  efx_ctrl #(
    .MAX_DEGREE (MAX_DEGREE),
    .EXP_BITS   (EXP_BITS),
    .NW         (NW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .coef_pos    (coef_pos),
    .exponent    (exponent),
    .n           (n_eff),
    .stat        (stat),
    .cmd         (cmd)
  );

  efx_datapath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .p               (p_eff),
    .coef_pos        (coef_pos),
    .coeff_in        (coeff_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .coef_pos_out    (coef_pos_out),
    .coeff_out       (coeff_out),
    .last            (last)
  );
endmodule
`default_nettype wire

// File: src/efx_mulmod.sv
// Bit-serial modular multiplier: r = a * b mod p, one bit of b per cycle.
`default_nettype none
module efx_mulmod
  import efx_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   go,
  input  wire coeff_t a,
  input  wire coeff_t b,
  input  wire coeff_t p,
  output logic        done,
  output coeff_t      r
);
  localparam int CNTW = $clog2(CW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  coeff_t          aa;
  coeff_t          bsh;
  logic [CW:0]     dbl, dbl_red, sum, sum_red;

  // double, reduce, add a on a set bit, reduce
  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
    sum     = dbl_red + (bsh[CW-1] ? {1'b0, aa} : '0);
    sum_red = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNTW'(CW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      r   <= '0;
      aa  <= a;
      bsh <= b;
    end else if (busy) begin
      r   <= sum_red[CW-1:0];
      bsh <= {bsh[CW-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

// File: src/efx_datapath.sv
// Coefficient stores, product accumulator, multiplier and output register.
`default_nettype none
module efx_datapath
  import efx_pkg::*;
#(
  parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire efx_cmd_t cmd,
  output efx_stat_t     stat,
  input  wire coeff_t   p,
  input  wire logic [3:0] coef_pos,
  input  wire coeff_t   coeff_in,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [3:0]    coef_pos_out,
  output coeff_t        coeff_out,
  output logic          last
);
  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int TW = $clog2(2 * MAX_DEGREE);

  coeff_t mst [MAX_DEGREE];
  coeff_t bst [MAX_DEGREE];
  coeff_t mreg[MAX_DEGREE];
  coeff_t pw  [MAX_DEGREE];
  coeff_t pr  [MAX_DEGREE];
  coeff_t tacc[2*MAX_DEGREE];

  coeff_t      areg, cin_r, bop, mr, tv;
  logic [3:0]  idx_r;
  logic        mdone;
  logic [IW-1:0] ai;
  logic [TW-1:0] at;
  logic [CW:0] tsum, tsum_red, tdif;

  assign ai = cmd.addr[IW-1:0];
  assign at = cmd.addr[TW-1:0];
  assign tv = tacc[at];

  always_comb begin
    case (cmd.b_src)
      B_CIN:    bop = cin_r;
      B_MSTORE: bop = mst[ai];
      B_BSTORE: bop = bst[ai];
      B_PR:     bop = pr[ai];
      B_PW:     bop = pw[ai];
      B_MREG:   bop = mreg[ai];
      default:  bop = '0;
    endcase
  end

  efx_mulmod u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.go),
    .a    (areg),
    .b    (bop),
    .p    (p),
    .done (mdone),
    .r    (mr)
  );

  always_comb begin
    tsum     = {1'b0, tv} + {1'b0, mr};
    tsum_red = (tsum >= {1'b0, p}) ? tsum - {1'b0, p} : tsum;
    tdif     = (tv >= mr) ? {1'b0, tv} - {1'b0, mr} : {1'b0, tv} + ({1'b0, p} - {1'b0, mr});
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cin_r <= coeff_in;
      idx_r <= coef_pos;
    end
    if (cmd.a_ld) begin
      case (cmd.a_src)
        A_PW:    areg <= pw[ai];
        A_T:     areg <= tv;
        default: areg <= coeff_t'(1);
      endcase
    end
    case (cmd.w_dst)
      W_MSTORE: mst[IW'(idx_r)] <= mr;
      W_BSTORE: bst[IW'(idx_r)] <= mr;
      W_MREG:   mreg[ai] <= mr;
      W_PW:     pw[ai] <= mr;
      W_TADD:   tacc[at] <= tsum_red[CW-1:0];
      W_TSUB:   tacc[at] <= tdif[CW-1:0];
      default: ;
    endcase
    if (cmd.t_clr) begin
      for (int e = 0; e < 2 * MAX_DEGREE; e++) tacc[e] <= '0;
    end
    if (cmd.pr_init) begin
      for (int e = 0; e < MAX_DEGREE; e++) pr[e] <= (e == 0) ? coeff_t'(1) : '0;
    end
    if (cmd.copy_pr) begin
      for (int e = 0; e < MAX_DEGREE; e++) pr[e] <= tacc[e];
    end
    if (cmd.copy_pw) begin
      for (int e = 0; e < MAX_DEGREE; e++) pw[e] <= tacc[e];
    end
    if (cmd.out_ld) begin
      coeff_out    <= pr[ai];
      coef_pos_out <= 4'(cmd.addr);
      last         <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.mul_done = mdone;
  assign stat.out_free = !out_valid || out_ready;
endmodule
`default_nettype wire

// File: src/efx_ctrl.sv
// Sequencer: loads, base setup, square-and-multiply loop, ring product and result drain.
`default_nettype none
module efx_ctrl
  import efx_pkg::*;
#(
  parameter int MAX_DEGREE = DEF_MAX_DEGREE,
  parameter int EXP_BITS   = DEF_EXP_BITS,
  parameter int NW         = $clog2(DEF_MAX_DEGREE + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    req_type,
  input  wire logic [3:0]    coef_pos,
  input  wire logic [63:0]   exponent,
  input  wire logic [NW-1:0] n,
  input  wire efx_stat_t     stat,
  output efx_cmd_t           cmd
);
  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int TW = $clog2(2 * MAX_DEGREE);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LD_GO   = 4'd1;
  localparam logic [3:0] S_LD_WAIT = 4'd2;
  localparam logic [3:0] S_INM_GO  = 4'd3;
  localparam logic [3:0] S_INM_WT  = 4'd4;
  localparam logic [3:0] S_INB_GO  = 4'd5;
  localparam logic [3:0] S_INB_WT  = 4'd6;
  localparam logic [3:0] S_EXP_CHK = 4'd7;
  localparam logic [3:0] S_RM_CLR  = 4'd8;
  localparam logic [3:0] S_RM_FA   = 4'd9;
  localparam logic [3:0] S_RM_GO   = 4'd10;
  localparam logic [3:0] S_RM_WT   = 4'd11;
  localparam logic [3:0] S_RD_FA   = 4'd12;
  localparam logic [3:0] S_RD_GO   = 4'd13;
  localparam logic [3:0] S_RD_WT   = 4'd14;
  localparam logic [3:0] S_RM_CPY  = 4'd15;

  logic [3:0]          state, state_next;
  logic                out_phase, out_phase_next;
  logic [IW-1:0]       i, i_next, j, j_next;
  logic [TW-1:0]       k, k_next;
  logic [EXP_BITS-1:0] e, e_next;
  logic                sq, sq_next, ldm, ldm_next;
  logic                acc, last_i, last_j;

  assign acc    = in_valid && in_ready;
  assign last_i = (NW'(i) == n - NW'(1));
  assign last_j = (NW'(j) == n - NW'(1));
  assign in_ready = (state == S_IDLE) && !out_phase;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_phase_next = out_phase;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    e_next         = e;
    sq_next        = sq;
    ldm_next       = ldm;
    if (out_phase) begin
      // drain result words, lowest coefficient first
      cmd.addr = AW'(i);
      if (stat.out_free) begin
        cmd.out_ld   = 1'b1;
        cmd.out_last = last_i;
        if (last_i) out_phase_next = 1'b0;
        else i_next = i + 1'b1;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            cmd.cap   = 1'b1;
            cmd.a_src = A_ONE;
            if ((req_type == REQ_LOAD_MOD || req_type == REQ_LOAD_BASE) &&
                (32'(coef_pos) < MAX_DEGREE)) begin
              cmd.a_ld   = 1'b1;
              ldm_next   = (req_type == REQ_LOAD_MOD);
              state_next = S_LD_GO;
            end else if (req_type == REQ_RUN) begin
              cmd.a_ld    = 1'b1;
              cmd.pr_init = 1'b1;
              e_next      = exponent[EXP_BITS-1:0];
              i_next      = '0;
              state_next  = S_INM_GO;
            end
          end
        end
        S_LD_GO: begin
          cmd.go     = 1'b1;
          cmd.b_src  = B_CIN;
          state_next = S_LD_WAIT;
        end
        S_LD_WAIT: begin
          if (stat.mul_done) begin
            cmd.w_dst  = ldm ? W_MSTORE : W_BSTORE;
            state_next = S_IDLE;
          end
        end
        S_INM_GO: begin
          cmd.go     = 1'b1;
          cmd.b_src  = B_MSTORE;
          cmd.addr   = AW'(i);
          state_next = S_INM_WT;
        end
        S_INM_WT: begin
          cmd.addr = AW'(i);
          if (stat.mul_done) begin
            cmd.w_dst  = W_MREG;
            state_next = S_INB_GO;
          end
        end
        S_INB_GO: begin
          cmd.go     = 1'b1;
          cmd.b_src  = B_BSTORE;
          cmd.addr   = AW'(i);
          state_next = S_INB_WT;
        end
        S_INB_WT: begin
          cmd.addr = AW'(i);
          if (stat.mul_done) begin
            cmd.w_dst = W_PW;
            if (last_i) state_next = S_EXP_CHK;
            else begin
              i_next     = i + 1'b1;
              state_next = S_INM_GO;
            end
          end
        end
        S_EXP_CHK: begin
          if (e == '0) begin
            i_next         = '0;
            out_phase_next = 1'b1;
            state_next     = S_IDLE;
          end else begin
            sq_next = !e[0];
            if (!e[0]) e_next = e >> 1;
            state_next = S_RM_CLR;
          end
        end
        S_RM_CLR: begin
          cmd.t_clr  = 1'b1;
          i_next     = '0;
          j_next     = '0;
          state_next = S_RM_FA;
        end
        S_RM_FA: begin
          cmd.a_ld   = 1'b1;
          cmd.a_src  = A_PW;
          cmd.addr   = AW'(i);
          state_next = S_RM_GO;
        end
        S_RM_GO: begin
          cmd.go     = 1'b1;
          cmd.b_src  = sq ? B_PW : B_PR;
          cmd.addr   = AW'(j);
          state_next = S_RM_WT;
        end
        S_RM_WT: begin
          cmd.addr = AW'(TW'(i) + TW'(j));
          if (stat.mul_done) begin
            cmd.w_dst = W_TADD;
            if (last_j) begin
              j_next = '0;
              if (last_i) begin
                if (n == NW'(1)) state_next = S_RM_CPY;
                else begin
                  k_next     = TW'(n) + TW'(n) - TW'(2);
                  state_next = S_RD_FA;
                end
              end else begin
                i_next     = i + 1'b1;
                state_next = S_RM_FA;
              end
            end else begin
              j_next     = j + 1'b1;
              state_next = S_RM_GO;
            end
          end
        end
        S_RD_FA: begin
          cmd.a_ld   = 1'b1;
          cmd.a_src  = A_T;
          cmd.addr   = AW'(k);
          i_next     = '0;
          state_next = S_RD_GO;
        end
        S_RD_GO: begin
          cmd.go     = 1'b1;
          cmd.b_src  = B_MREG;
          cmd.addr   = AW'(i);
          state_next = S_RD_WT;
        end
        S_RD_WT: begin
          cmd.addr = AW'(k - TW'(n) + TW'(i));
          if (stat.mul_done) begin
            cmd.w_dst = W_TSUB;
            if (last_i) begin
              if (k == TW'(n)) state_next = S_RM_CPY;
              else begin
                k_next     = k - 1'b1;
                state_next = S_RD_FA;
              end
            end else begin
              i_next     = i + 1'b1;
              state_next = S_RD_GO;
            end
          end
        end
        S_RM_CPY: begin
          if (sq) begin
            cmd.copy_pw = 1'b1;
            state_next  = S_EXP_CHK;
          end else begin
            cmd.copy_pr = 1'b1;
            e_next      = e >> 1;
            if ((e >> 1) == '0) begin
              i_next         = '0;
              out_phase_next = 1'b1;
              state_next     = S_IDLE;
            end else begin
              sq_next    = 1'b1;
              state_next = S_RM_CLR;
            end
          end
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_phase <= 1'b0;
      e         <= '0;
    end else begin
      state     <= state_next;
      out_phase <= out_phase_next;
      e         <= e_next;
    end
  end

  always_ff @(posedge clk) begin
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
    sq  <= sq_next;
    ldm <= ldm_next;
  end
endmodule
`default_nettype wire

// File: src/efx_checker.sv
// Port-level checks for the exponentiation core, bound to the top level.
`default_nettype none
module efx_checker
  import efx_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  req_type,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [61:0] coeff_out,
  input wire logic        last
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coeff_out))
    else $error("output word dropped or changed while stalled");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == REQ_RUN |=> !in_ready)
    else $error("input taken right after a run word");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_no_in_mid_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input ready while a result is still draining");
endmodule

bind ext_field_exponentiation_core efx_checker u_efx_checker (.*);
`default_nettype wire

// File: bench/ext_field_exponentiation_core_tb.sv
// Self-checking bench for the extension-field exponentiation core.
`timescale 1ns / 100ps
`default_nettype none
module ext_field_exponentiation_core_tb;
  import efx_pkg::*;

  localparam int MAXD       = DEF_MAX_DEGREE;
  localparam int HUSH_LIMIT = 400000;  // cycles with no word moving on either channel
  localparam int HOLD_LEN   = 3000;    // long output hold-off
  localparam int SETTLE     = 150;     // covers a trailing load word, which gives no output

  typedef coeff_t poly_t [MAXD];

  // expected result word
  typedef struct {
    logic [3:0] idx;
    coeff_t     val;
    logic       last;
  } coeff_word_t;

  // one row of the directed table; value is cfg data or coeff_in
  typedef struct {
    bit         is_cfg;
    logic       cfg_sel;
    coeff_t     value;
    logic [1:0] req;
    logic [3:0] idx;
    logic [63:0] ex;
    bit         typed;
    coeff_t     typed_val;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [61:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [3:0]  coef_pos = '0;
  logic [61:0] coeff_in = '0;
  logic [63:0] exponent = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  coef_pos_out;
  logic [61:0] coeff_out;
  logic        last;

  ext_field_exponentiation_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .coef_pos(coef_pos), .coeff_in(coeff_in), .exponent(exponent),
    .out_valid(out_valid), .out_ready(out_ready),
    .coef_pos_out(coef_pos_out), .coeff_out(coeff_out), .last(last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------
  // Predictor state: its own copy of the registers and both stores
  // ---------------------------------------------------------------
  coeff_t      char_reg = 62'd2;
  logic [4:0]  degree_reg = 5'd1;
  poly_t       fpoly_mem;
  poly_t       base_mem;
  coeff_word_t pending_coeffs[$];

  int errors = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;

  function automatic coeff_t char_p();
    return (char_reg < 62'd2) ? 62'd2 : char_reg;
  endfunction

  function automatic int degree_n();
    if (degree_reg == 5'd0) return 1;
    if (degree_reg > 5'(MAXD)) return MAXD;
    return int'(degree_reg);
  endfunction

  function automatic coeff_t mul_modp(coeff_t a, coeff_t b, coeff_t p);
    logic [123:0] prod;
    prod = 124'(a) * 124'(b);
    return coeff_t'(prod % 124'(p));
  endfunction

  function automatic coeff_t add_modp(coeff_t a, coeff_t b, coeff_t p);
    logic [62:0] s;
    s = 63'(a) + 63'(b);
    return (s >= 63'(p)) ? coeff_t'(s - 63'(p)) : coeff_t'(s);
  endfunction

  function automatic coeff_t sub_modp(coeff_t a, coeff_t b, coeff_t p);
    return (a >= b) ? a - b : a + (p - b);
  endfunction

  // x*y in GF(p)[x]/f, f monic with low coefficients m
  function automatic poly_t ring_product(poly_t x, poly_t y, poly_t m, int n, coeff_t p);
    coeff_t t[2*MAXD];
    coeff_t c;
    poly_t  r;
    for (int k = 0; k < 2*MAXD; k++) t[k] = '0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        t[i+j] = add_modp(t[i+j], mul_modp(x[i], y[j], p), p);
    // fold the top terms down using x^n = -(m[n-1]x^(n-1) + ... + m[0])
    for (int k = 2*n - 2; k >= n; k--) begin
      c = t[k];
      t[k] = '0;
      if (c != '0)
        for (int i = 0; i < n; i++)
          t[k-n+i] = sub_modp(t[k-n+i], mul_modp(c, m[i], p), p);
    end
    for (int i = 0; i < MAXD; i++) r[i] = (i < n) ? t[i] : '0;
    return r;
  endfunction

  // right-to-left square-and-multiply, queues n result words
  task automatic predict_power(logic [63:0] ex);
    coeff_t      p;
    int          n;
    poly_t       m, pw, acc;
    logic [63:0] bits;
    p = char_p();
    n = degree_n();
    bits = ex;
    for (int i = 0; i < MAXD; i++) begin
      m[i]   = fpoly_mem[i] % p;   // stores re-reduced if p changed since loading
      pw[i]  = (i < n) ? base_mem[i] % p : '0;
      acc[i] = '0;
    end
    acc[0] = 62'd1;
    while (bits != '0) begin
      if (bits[0]) acc = ring_product(pw, acc, m, n, p);
      bits = bits >> 1;
      if (bits != '0) pw = ring_product(pw, pw, m, n, p);
    end
    for (int i = 0; i < n; i++)
      pending_coeffs.push_back('{4'(i), acc[i], (i == n - 1)});
  endtask

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    errors++;
  endtask

  // ---------------------------------------------------------------
  // Receive side: compare, stall at random, long hold on request,
  // and watchdog on cycles where no word moves
  // ---------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;
  int hush = 0;

  always @(posedge clk) begin
    coeff_word_t want;
    if (out_valid && out_ready) begin
      if (pending_coeffs.size() == 0) begin
        report_mismatch($sformatf("unexpected word idx=%0d val=%0h", coef_pos_out, coeff_out));
      end else begin
        want = pending_coeffs.pop_front();
        if (coef_pos_out !== want.idx)
          report_mismatch($sformatf("coef_pos_out %0d, want %0d", coef_pos_out, want.idx));
        if (coeff_out !== want.val)
          report_mismatch($sformatf("coeff_out[%0d] %0h, want %0h", want.idx, coeff_out, want.val));
        if (last !== want.last)
          report_mismatch($sformatf("last on idx %0d is %b, want %b", want.idx, last, want.last));
      end
    end

    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) hush = 0;
      else hush++;
      if (hush >= HUSH_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end

    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------
  // Send side
  // ---------------------------------------------------------------
  // offers one word; prediction happens at the accepting edge
  task automatic offer_word(logic [1:0] req, logic [3:0] idx, coeff_t cin, logic [63:0] ex,
                            bit typed, coeff_t tval);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    coef_pos    <= idx;
    coeff_in    <= cin;
    exponent    <= ex;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (req)
      REQ_LOAD_MOD:  fpoly_mem[idx] = cin % char_p();
      REQ_LOAD_BASE: base_mem[idx]  = cin % char_p();
      REQ_RUN: begin
        if (typed) pending_coeffs.push_back('{4'd0, tval, 1'b1});
        else predict_power(ex);
      end
      default: ;  // unused request type, no result
    endcase
  endtask

  // quiet the input, wait out all results and any trailing load
  task automatic drain_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_coeffs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, logic [61:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_MODULUS) char_reg = data;
    else degree_reg = data[4:0];
    @(posedge clk);
  endtask

  function automatic coeff_t rand_coeff();
    return coeff_t'({$urandom(), $urandom()});
  endfunction

  function automatic coeff_t pick_modulus();
    case ($urandom_range(0, 7))
      0: return 62'd2;
      1: return 62'd3;
      2: return 62'd13;
      3: return 62'd65537;
      4: return 62'd2147483647;
      5: return 62'd2305843009213693951;   // 2^61-1
      6: return 62'h3FFFFFFFFFFFFFFF;      // largest value
      default: return rand_coeff() | 62'd1;
    endcase
  endfunction

  // exponent length kept to what the field size allows in run time
  function automatic logic [63:0] pick_exponent(int n);
    if (n == 1) return {$urandom(), $urandom()};
    if (n <= 3) return 64'($urandom_range(0, 4095));
    return 64'($urandom_range(0, 15));
  endfunction

  // mostly loads with random content followed by runs, some noise words
  task automatic random_burst(int count);
    int done;
    int pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        offer_word(2'd3, 4'($urandom()), rand_coeff(), {$urandom(), $urandom()}, 1'b0, '0);
      end else if (pick < 65) begin
        offer_word(($urandom_range(1) == 0) ? REQ_LOAD_MOD : REQ_LOAD_BASE,
                   4'($urandom()), rand_coeff(), {$urandom(), $urandom()}, 1'b0, '0);
        done++;
      end else begin
        offer_word(REQ_RUN, 4'($urandom()), rand_coeff(), pick_exponent(degree_n()), 1'b0, '0);
        done++;
      end
    end
  endtask

  dir_row_t dir_rows[$];

  initial begin
    int deg;
    // reset at the start only, never again
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill both stores so that no run ever reads an unwritten entry
    write_reg(CFG_MODULUS, rand_coeff());
    for (int i = 0; i < MAXD; i++) begin
      offer_word(REQ_LOAD_MOD, 4'(i), rand_coeff(), '0, 1'b0, '0);
      offer_word(REQ_LOAD_BASE, 4'(i), rand_coeff(), '0, 1'b0, '0);
    end

    // directed: cfg, value, req, idx, exponent, typed expectation
    dir_rows = '{
      // modulus below two acts as two, degree zero as one
      '{1, CFG_MODULUS, 62'd0, REQ_RUN, 4'd0, 64'd0, 0, 62'd0},
      '{1, CFG_DEGREE,  62'd0, REQ_RUN, 4'd0, 64'd0, 0, 62'd0},
      '{0, CFG_MODULUS, 62'h3FFFFFFFFFFFFFFF, REQ_LOAD_BASE, 4'd0, 64'd0, 0, 62'd0},
      '{0, CFG_MODULUS, 62'd0, REQ_RUN, 4'd0, 64'd0, 1, 62'd1},               // x^0 = 1
      '{0, CFG_MODULUS, 62'd0, REQ_RUN, 4'd0, 64'd1, 1, 62'd1},
      '{0, CFG_MODULUS, 62'd0, REQ_RUN, 4'd0, 64'hFFFFFFFFFFFFFFFF, 1, 62'd1},
      '{0, CFG_MODULUS, 62'd2, REQ_LOAD_BASE, 4'd0, 64'd0, 0, 62'd0},        // base 0
      '{0, CFG_MODULUS, 62'd0, REQ_RUN, 4'd0, 64'd5, 1, 62'd0},
      '{0, CFG_MODULUS, 62'd0, REQ_RUN, 4'd0, 64'd0, 1, 62'd1},
      '{0, CFG_MODULUS, 62'h3FFFFFFFFFFFFFFF, 2'd3, 4'hF, 64'hFFFFFFFFFFFFFFFF, 0, 62'd0},
      '{1, CFG_MODULUS, 62'd1, REQ_RUN, 4'd0, 64'd0, 0, 62'd0},
      '{0, CFG_MODULUS, 62'd1, REQ_RUN, 4'd0, 64'd0, 1, 62'd1},
      // largest modulus, degree above the maximum clamps to sixteen
      '{1, CFG_MODULUS, 62'h3FFFFFFFFFFFFFFF, REQ_RUN, 4'd0, 64'd0, 0, 62'd0},
      '{1, CFG_DEGREE,  62'd31, REQ_RUN, 4'd0, 64'd0, 0, 62'd0},
      '{0, CFG_MODULUS, 62'h3FFFFFFFFFFFFFFE, REQ_LOAD_BASE, 4'd15, 64'd0, 0, 62'd0},
      '{0, CFG_MODULUS, 62'h3FFFFFFFFFFFFFFF, REQ_LOAD_MOD, 4'd15, 64'd0, 0, 62'd0},
      '{0, CFG_MODULUS, 62'd0, REQ_RUN, 4'd0, 64'd1, 0, 62'd0},
      '{0, CFG_MODULUS, 62'd0, REQ_RUN, 4'd0, 64'd2, 0, 62'd0},
      // small field, then shrink the modulus under the loaded values
      '{1, CFG_DEGREE,  62'd2, REQ_RUN, 4'd0, 64'd0, 0, 62'd0},
      '{1, CFG_MODULUS, 62'd13, REQ_RUN, 4'd0, 64'd0, 0, 62'd0},
      '{0, CFG_MODULUS, 62'd2, REQ_LOAD_MOD, 4'd0, 64'd0, 0, 62'd0},
      '{0, CFG_MODULUS, 62'd12, REQ_LOAD_BASE, 4'd1, 64'd0, 0, 62'd0},
      '{0, CFG_MODULUS, 62'd0, REQ_RUN, 4'd0, 64'd12, 0, 62'd0},
      '{1, CFG_MODULUS, 62'd5, REQ_RUN, 4'd0, 64'd0, 0, 62'd0},
      '{0, CFG_MODULUS, 62'd0, REQ_RUN, 4'd0, 64'd3, 0, 62'd0}
    };
    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        drain_idle();
        write_reg(dir_rows[r].cfg_sel, dir_rows[r].value);
      end else begin
        offer_word(dir_rows[r].req, dir_rows[r].idx, dir_rows[r].value, dir_rows[r].ex,
                   dir_rows[r].typed, dir_rows[r].typed_val);
      end
    end

    // random phases: no idling, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct   = (ph == 1) ? 53 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 36 : 0;
      for (int sub = 0; sub < 2; sub++) begin
        drain_idle();   // sender pauses until every result is back
        deg = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        write_reg(CFG_MODULUS, pick_modulus());
        write_reg(CFG_DEGREE, 62'(deg));
        if (ph == 0 && sub == 0) begin
          // long output hold-off while runs keep coming: the core backs up;
          // the first run is short so its results land well inside the hold
          hold_req++;
          for (int k = 0; k < 3; k++)
            offer_word(REQ_RUN, 4'd0, '0, (k == 0) ? 64'd0 : pick_exponent(degree_n()),
                       1'b0, '0);
        end
        random_burst(6);
      end
    end

    drain_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: ext_field_exponentiation_core.f
src/efx_pkg.sv
src/efx_mulmod.sv
src/efx_datapath.sv
src/efx_ctrl.sv
src/ext_field_exponentiation_core.sv
src/efx_checker.sv
bench/ext_field_exponentiation_core_tb.sv
